### sv/llbe_pkg.sv
// ----------------------------------------------------------------------------
// llbe_pkg
// Shared constants, field widths and operation codes of the landmark
// lower-bound engine.
// ----------------------------------------------------------------------------
package llbe_pkg;

  // node count per table row; sets the width of the node index field
  localparam int MAX_NODES = 4096;
  localparam int NODE_W    = $clog2(MAX_NODES);

  // defaults of the top-level parameters
  localparam int DEF_MAX_LANDMARKS = 16;
  localparam int DEF_DIST_BITS     = 32;

  // port field widths
  localparam int OP_W     = 3;
  localparam int LMIDX_W  = 4;
  localparam int VALUE_W  = 32;
  localparam int RESULT_W = 32;
  localparam int ACTIVE_W = 5;

  // active landmark count after reset
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WR_TO   = 3'd0,
    OP_WR_FROM = 3'd1,
    OP_QUERY   = 3'd2,
    OP_RD_TO   = 3'd3,
    OP_RD_FROM = 3'd4
  } op_e;

endpackage

### sv/landmark_lower_bound_engine.sv
// ----------------------------------------------------------------------------
// landmark_lower_bound_engine
// Landmark triangle-inequality lower bound over two distance tables held in
// synchronous memories, with table writes and single-entry reads.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer:
//   op, source and target node, landmark index and distance. Output channel
//   (out_valid_o / out_stall_i) carries one result_value per read or query.
//   Writes and unknown ops produce no result.
//   The config channel (cfg_valid_i / cfg_ready_o) sets the active landmark
//   count; it is ready whenever no item is in progress.
// Sequence
//   A write completes at its transfer. A read passes the issue, data and
//   finish states before it reaches the output register; a query runs the
//   n active landmarks and then the finish state, where n is the active
//   landmark count: each table has two read ports, so one landmark's four
//   entries are fetched per cycle, followed by a two-stage difference and
//   maximum pipeline. The next item is taken in the cycle after the result
//   is loaded. One item is in progress at a time.
// Reset and stall
//   Reset clears control state and sets the active count to 16; the tables
//   are undefined until written. A finished result waits in the output
//   register while the receiver stalls, and the next item is still taken;
//   only a further result waits for the output register to free up.
// ----------------------------------------------------------------------------
module landmark_lower_bound_engine
  import llbe_pkg::*;
#(
  parameter int MAX_LANDMARKS = DEF_MAX_LANDMARKS,
  parameter int DIST_BITS     = DEF_DIST_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ACTIVE_W-1:0] cfg_active_landmarks_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [NODE_W-1:0]   source_node_i,
  input  logic [NODE_W-1:0]   target_node_i,
  input  logic [LMIDX_W-1:0]  landmark_index_i,
  input  logic [VALUE_W-1:0]  distance_value_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RESULT_W-1:0] result_value_o
);

  localparam int LM_W   = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int ADDR_W = LM_W + NODE_W;
  localparam int DEPTH  = MAX_LANDMARKS * MAX_NODES;
  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_ISSUE,
    S_RD_DATA,
    S_Q_RUN,
    S_FINISH
  } state_e;

  // control state
  state_e                state_q, state_d;
  logic [ACTIVE_W-1:0]   active_q, active_d;
  logic [ACTIVE_W-1:0]   cnt_q, cnt_d;
  logic                  dv_q, dv_d;
  logic                  tv_q, tv_d;
  logic                  out_valid_q, out_valid_d;
  logic [RESULT_W-1:0]   result_q, result_d;

  // item registers
  op_e                   op_q;
  logic [NODE_W-1:0]     src_q;
  logic [NODE_W-1:0]     dst_q;
  logic [LMIDX_W-1:0]    lm_q;

  // datapath registers
  logic [DIST_BITS-1:0]  to_a_q, to_b_q, from_a_q, from_b_q;
  logic [DIST_BITS-1:0]  t1_q, t2_q;
  logic [DIST_BITS-1:0]  best_q;

  // tables
  logic [DIST_BITS-1:0]  to_mem   [DEPTH];
  logic [DIST_BITS-1:0]  from_mem [DEPTH];

  logic                  in_xfer;
  logic                  cfg_xfer;
  logic                  out_free;
  logic [ACTIVE_W-1:0]   n_eff;
  logic                  lm_wr_ok;
  logic                  lm_rd_ok;
  logic                  wr_to;
  logic                  wr_from;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DIST_BITS-1:0]  wr_data;
  logic                  rd_en;
  logic                  q_issue;
  logic [LM_W-1:0]       rd_row;
  logic [ADDR_W-1:0]     addr_a;
  logic [ADDR_W-1:0]     addr_b;
  logic [DIST_BITS-1:0]  t1_d, t2_d;
  logic [DIST_BITS-1:0]  max_a;
  logic [DIST_BITS-1:0]  best_acc;

  // contribution of minuend a minus subtrahend b, zero when ignored
  function automatic logic [DIST_BITS-1:0] diff_term(input logic [DIST_BITS-1:0] a,
                                                     input logic [DIST_BITS-1:0] b);
    logic [DIST_BITS-1:0] r;
    if (b == DIST_INF) begin
      r = '0;
    end else if (a == DIST_INF) begin
      r = DIST_INF;
    end else if (a > b) begin
      r = a - b;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;

  // effective landmark count, saturated at the table row count
  assign n_eff = (32'(active_q) > MAX_LANDMARKS) ? ACTIVE_W'(MAX_LANDMARKS) : active_q;

  // table write port
  assign lm_wr_ok = (32'(landmark_index_i) < MAX_LANDMARKS);
  assign wr_to    = in_xfer && (op_e'(op_i) == OP_WR_TO) && lm_wr_ok;
  assign wr_from  = in_xfer && (op_e'(op_i) == OP_WR_FROM) && lm_wr_ok;
  assign wr_addr  = {LM_W'(landmark_index_i), source_node_i};
  assign wr_data  = DIST_BITS'(distance_value_i);

  // read ports: port a at the source node, port b at the target node
  assign lm_rd_ok = ({1'b0, lm_q} < n_eff);
  assign q_issue  = (state_q == S_Q_RUN) && (cnt_q < n_eff);
  assign rd_en    = q_issue || ((state_q == S_RD_ISSUE) && lm_rd_ok);
  assign rd_row   = (state_q == S_Q_RUN) ? LM_W'(cnt_q) : LM_W'(lm_q);
  assign addr_a   = {rd_row, src_q};
  assign addr_b   = {rd_row, dst_q};

  // table storage
  always_ff @(posedge clk_i) begin
    if (wr_to) begin
      to_mem[wr_addr] <= wr_data;
    end
    if (wr_from) begin
      from_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      to_a_q   <= to_mem[addr_a];
      to_b_q   <= to_mem[addr_b];
      from_a_q <= from_mem[addr_a];
      from_b_q <= from_mem[addr_b];
    end
  end

  // difference terms of one landmark, and running maximum
  assign t1_d     = diff_term(to_a_q, to_b_q);
  assign t2_d     = diff_term(from_b_q, from_a_q);
  assign max_a    = (t1_q > best_q) ? t1_q : best_q;
  assign best_acc = (t2_q > max_a) ? t2_q : max_a;

  // item and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= op_e'(op_i);
      src_q <= source_node_i;
      dst_q <= target_node_i;
      lm_q  <= landmark_index_i;
    end
    if (dv_q) begin
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
    if (in_xfer) begin
      best_q <= '0;
    end else if (state_q == S_RD_DATA) begin
      if (!lm_rd_ok) begin
        best_q <= DIST_INF;
      end else if (op_q == OP_RD_TO) begin
        best_q <= to_a_q;
      end else begin
        best_q <= from_a_q;
      end
    end else if (tv_q) begin
      best_q <= best_acc;
    end
  end

  // next state and control
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    cnt_d       = cnt_q;
    dv_d        = q_issue;
    tv_d        = dv_q;
    out_valid_d = out_valid_q && out_stall_i;
    result_d    = result_q;
    if (cfg_xfer) begin
      active_d = cfg_active_landmarks_i;
    end
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (op_e'(op_i))
            OP_QUERY: begin
              cnt_d   = '0;
              state_d = S_Q_RUN;
            end
            OP_RD_TO, OP_RD_FROM: state_d = S_RD_ISSUE;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD_ISSUE: state_d = S_RD_DATA;
      S_RD_DATA:  state_d = S_FINISH;
      S_Q_RUN: begin
        if (q_issue) begin
          cnt_d = cnt_q + 1'b1;
        end else if (!dv_q && !tv_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          result_d    = RESULT_W'(best_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= ACTIVE_RESET;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      tv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      dv_q        <= dv_d;
      tv_q        <= tv_d;
      out_valid_q <= out_valid_d;
      result_q    <= result_d;
    end
  end

  // checks
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!dv_q && !tv_q))
    else $error("landmark pipeline busy while idle");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_FINISH))
    else $error("result loaded outside finish state");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_RUN) |-> (cnt_q <= n_eff))
    else $error("landmark counter beyond active count");

  a_terms_follow_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |=> tv_q)
    else $error("term stage lost a landmark");

endmodule
